### design/bta_pkg.sv
`timescale 1ns / 1ps
package bta_pkg;
    localparam int OFF_W            = 16;
    localparam int LINK_W           = OFF_W - 3;
    localparam int SIZE_W           = 16;
    localparam int NEED_W           = 17;
    localparam int HEADER_BYTES     = 24;
    localparam int ALIGN_BYTES      = 8;
    localparam int MIN_PAYLOAD      = 8;
    localparam int ARENA_BYTES_DEF  = 65536;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_ZERO  = 2'd2;

    // One boundary-tag header; links hold 8-byte slot indexes
    typedef struct packed {
        logic              bfree;
        logic              free;
        logic [SIZE_W-1:0] bsize;
        logic [SIZE_W-1:0] size;
        logic              has_next;
        logic              has_prev;
        logic [LINK_W-1:0] next;
        logic [LINK_W-1:0] prev;
    } hdr_t;

    // Request to the shared offset unit
    typedef struct packed {
        logic              sub;
        logic [OFF_W-1:0]  a;
        logic [NEED_W-1:0] b;
    } alu_op_t;
endpackage

### design/bta_ram.sv
`timescale 1ns / 1ps
module bta_ram #(
    parameter int WIDTH = 62,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry, read one entry registered
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### design/bta_alu.sv
`timescale 1ns / 1ps
module bta_alu #(
    parameter int ARENA_BYTES = 65536
) (
    input  bta_pkg::alu_op_t          op,
    output logic [bta_pkg::OFF_W-1:0] res
);
    import bta_pkg::*;

    localparam logic [17:0] ARENA18 = 18'(ARENA_BYTES);
    localparam logic [17:0] HDR18   = 18'(HEADER_BYTES);

    logic [17:0] d_raw;
    logic [17:0] d_mod;
    logic [17:0] s_raw;
    logic [17:0] s_mod;

    // Add header plus size forward, or step back over the previous block
    always_comb
    begin
        d_raw = HDR18 + {1'b0, op.b};
        d_mod = (d_raw >= ARENA18) ? (d_raw - ARENA18) : d_raw;
        if (op.sub)
        begin
            s_raw = {2'b00, op.a} + ARENA18 - d_mod;
        end
        else
        begin
            s_raw = {2'b00, op.a} + d_raw;
        end
        s_mod = (s_raw >= ARENA18) ? (s_raw - ARENA18) : s_raw;
        res   = {s_mod[OFF_W-1:3], 3'b000};
    end
endmodule

### design/boundary_tag_first_fit_allocator_unit.sv
`timescale 1ns / 1ps
// First-fit heap allocator over one arena of ARENA_BYTES bytes with 24-byte
// boundary-tag headers kept in a single-port-pair header RAM, one entry per
// 8-byte slot. One command is handled at a time; every header access is a
// read followed by an optional write, through one shared offset adder. An
// allocate takes longer for each free-list entry that it visits. A zero
// request, an allocate on an empty free list or a null free goes straight
// to the output step. A result that waits for the receiver holds the block
// in its output step. The arena is ready right after reset with no clearing
// pass: the first block and the sentinel read as their reset values until
// first written.
module boundary_tag_first_fit_allocator_unit #(
    parameter int ARENA_BYTES = bta_pkg::ARENA_BYTES_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      cmd,
    input  logic [15:0]               request_bytes,
    input  logic [15:0]               payload_offset,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [15:0]               granted_offset,
    output logic [1:0]                status
);
    import bta_pkg::*;

    localparam int DEPTH     = ARENA_BYTES / 8;
    localparam int SLOT_W    = $clog2(DEPTH);
    localparam int SLOTS     = DEPTH + 1;
    localparam int VIS_W     = $clog2(SLOTS + 1);
    localparam int SENT_OFF  = ((ARENA_BYTES - HEADER_BYTES) % ARENA_BYTES) / 8 * 8;
    localparam logic [SLOT_W-1:0] SENT_SLOT = SLOT_W'(SENT_OFF / 8);
    localparam logic [SIZE_W-1:0] INIT_SZ   = SIZE_W'(ARENA_BYTES - 2 * HEADER_BYTES);
    localparam logic [SIZE_W-1:0] HDR16     = SIZE_W'(HEADER_BYTES);
    localparam logic [17:0]       SPLIT_MIN = 18'(MIN_PAYLOAD + HEADER_BYTES);
    localparam logic [VIS_W-1:0]  VIS_LAST  = VIS_W'(SLOTS);
    localparam hdr_t INIT0 = '{1'b0, 1'b1, 16'd0, INIT_SZ, 1'b0, 1'b0, 13'd0, 13'd0};
    localparam hdr_t INITS = '{1'b1, 1'b0, INIT_SZ, 16'd0, 1'b0, 1'b0, 13'd0, 13'd0};

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_WALK    = 5'd1;
    localparam logic [4:0] S_UN_N    = 5'd2;
    localparam logic [4:0] S_UN_P    = 5'd3;
    localparam logic [4:0] S_A_SPLIT = 5'd4;
    localparam logic [4:0] S_A_UP    = 5'd5;
    localparam logic [4:0] S_A_UPN   = 5'd6;
    localparam logic [4:0] S_PUSH    = 5'd7;
    localparam logic [4:0] S_PUSH_H  = 5'd8;
    localparam logic [4:0] S_A_FREE0 = 5'd9;
    localparam logic [4:0] S_A_NB    = 5'd10;
    localparam logic [4:0] S_F_B     = 5'd11;
    localparam logic [4:0] S_F_PREV  = 5'd12;
    localparam logic [4:0] S_F_BEF   = 5'd13;
    localparam logic [4:0] S_F_MA    = 5'd14;
    localparam logic [4:0] S_F_MB    = 5'd15;
    localparam logic [4:0] S_F_A     = 5'd16;
    localparam logic [4:0] S_F_MC    = 5'd17;
    localparam logic [4:0] S_F_MD    = 5'd18;
    localparam logic [4:0] S_F_FIN   = 5'd19;
    localparam logic [4:0] S_F_AFT   = 5'd20;
    localparam logic [4:0] S_OUT     = 5'd21;

    function automatic logic [SLOT_W-1:0] slot_of(input logic [OFF_W-1:0] o);
        return o[SLOT_W+2:3];
    endfunction

    function automatic logic [OFF_W-1:0] off_of(input logic [LINK_W-1:0] l);
        return {l, 3'b000};
    endfunction

    logic [4:0]        state_reg, state_next, uret_reg, uret_next;
    logic              ph_reg, ph_next;
    logic [OFF_W-1:0]  f_reg, f_next, up_reg, up_next, nb_reg, nb_next;
    logic [OFF_W-1:0]  bef_reg, bef_next, aft_reg, aft_next;
    logic [OFF_W-1:0]  un_reg, un_next, upr_reg, upr_next;
    logic              uhn_reg, uhn_next, uhp_reg, uhp_next;
    logic [NEED_W-1:0] need_reg, need_next;
    logic [SIZE_W-1:0] cur_reg, cur_next, bbs_reg, bbs_next;
    logic              tfree_reg, tfree_next;
    logic [VIS_W-1:0]  vis_reg, vis_next;
    logic [OFF_W-1:0]  head_reg, head_next;
    logic              hv_reg, hv_next;
    logic [OFF_W-1:0]  res_off_reg, res_off_next;
    logic [1:0]        res_st_reg, res_st_next;
    logic              out_valid_reg, out_valid_next;
    logic [OFF_W-1:0]  out_off_reg, out_off_next;
    logic [1:0]        out_st_reg, out_st_next;
    logic              w0_reg, ws_reg;
    logic [SLOT_W-1:0] rd_slot_reg;

    logic [OFF_W-1:0]  acc_off;
    logic [SLOT_W-1:0] acc_slot;
    logic [$bits(hdr_t)-1:0] ram_rdata;
    hdr_t              rd_hdr, wr_hdr;
    logic              we;
    alu_op_t           alu_op;
    logic [OFF_W-1:0]  alu_res;
    logic [NEED_W-1:0] need_min, need_calc;
    logic [SIZE_W-1:0] rs;

    bta_ram #(.WIDTH($bits(hdr_t)), .DEPTH(DEPTH)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (acc_slot),
        .wdata (wr_hdr),
        .raddr (acc_slot),
        .rdata (ram_rdata)
    );

    bta_alu #(.ARENA_BYTES(ARENA_BYTES)) u_alu (
        .op  (alu_op),
        .res (alu_res)
    );

    assign in_ready       = (state_reg == S_IDLE);
    assign out_valid      = out_valid_reg;
    assign granted_offset = out_off_reg;
    assign status         = out_st_reg;

    // Round the request up to the minimum and the alignment
    assign need_min  = (request_bytes < 16'(MIN_PAYLOAD)) ? NEED_W'(MIN_PAYLOAD)
                                                          : {1'b0, request_bytes};
    assign need_calc = (need_min + NEED_W'(ALIGN_BYTES - 1)) & ~NEED_W'(ALIGN_BYTES - 1);
    assign rs        = rd_hdr.size - need_reg[SIZE_W-1:0] - HDR16;

    // Present reset headers until their slots are first written
    always_comb
    begin
        rd_hdr = hdr_t'(ram_rdata);
        if ((rd_slot_reg == '0) && !w0_reg)
        begin
            rd_hdr = INIT0;
        end
        else if ((rd_slot_reg == SENT_SLOT) && !ws_reg)
        begin
            rd_hdr = INITS;
        end
    end

    // Select the header that the current step touches
    always_comb
    begin
        case (state_reg)
            S_UN_N:                    acc_off = un_reg;
            S_UN_P:                    acc_off = upr_reg;
            S_A_UP:                    acc_off = up_reg;
            S_A_UPN, S_A_NB, S_F_MD:   acc_off = nb_reg;
            S_PUSH_H:                  acc_off = head_reg;
            S_F_BEF, S_F_MB:           acc_off = bef_reg;
            S_F_MA, S_F_A, S_F_AFT:    acc_off = aft_reg;
            default:                   acc_off = f_reg;
        endcase
    end
    assign acc_slot = slot_of(acc_off);

    // Sequence header reads and writes
    always_comb
    begin
        state_next     = state_reg;
        ph_next        = ph_reg;
        uret_next      = uret_reg;
        f_next         = f_reg;
        up_next        = up_reg;
        nb_next        = nb_reg;
        bef_next       = bef_reg;
        aft_next       = aft_reg;
        un_next        = un_reg;
        upr_next       = upr_reg;
        uhn_next       = uhn_reg;
        uhp_next       = uhp_reg;
        need_next      = need_reg;
        cur_next       = cur_reg;
        bbs_next       = bbs_reg;
        tfree_next     = tfree_reg;
        vis_next       = vis_reg;
        head_next      = head_reg;
        hv_next        = hv_reg;
        res_off_next   = res_off_reg;
        res_st_next    = res_st_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        out_off_next   = out_off_reg;
        out_st_next    = out_st_reg;
        wr_hdr         = rd_hdr;
        we             = 1'b0;
        alu_op         = '{1'b0, f_reg, '0};

        case (state_reg)
            S_IDLE:
            begin
                alu_op = '{1'b1, payload_offset, '0};
                if (in_valid)
                begin
                    res_off_next = '0;
                    res_st_next  = ST_DONE;
                    if (cmd == CMD_ALLOC)
                    begin
                        need_next = need_calc;
                        f_next    = head_reg;
                        vis_next  = '0;
                        if (request_bytes == '0)
                        begin
                            res_st_next = ST_ZERO;
                            state_next  = S_OUT;
                        end
                        else if (!hv_reg)
                        begin
                            res_st_next = ST_NOFIT;
                            state_next  = S_OUT;
                        end
                        else
                        begin
                            state_next = S_WALK;
                        end
                    end
                    else if (payload_offset == '0)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        f_next     = alu_res;
                        state_next = S_F_B;
                    end
                end
            end
            S_WALK:
            begin
                if (!ph_reg)
                begin
                    ph_next = 1'b1;
                end
                else
                begin
                    ph_next = 1'b0;
                    if ({1'b0, rd_hdr.size} >= need_reg)
                    begin
                        uhn_next   = rd_hdr.has_next;
                        uhp_next   = rd_hdr.has_prev;
                        un_next    = off_of(rd_hdr.next);
                        upr_next   = off_of(rd_hdr.prev);
                        uret_next  = S_A_SPLIT;
                        state_next = S_UN_N;
                    end
                    else if (!rd_hdr.has_next || (vis_reg + 1'b1 == VIS_LAST))
                    begin
                        res_st_next = ST_NOFIT;
                        state_next  = S_OUT;
                    end
                    else
                    begin
                        f_next   = off_of(rd_hdr.next);
                        vis_next = vis_reg + 1'b1;
                    end
                end
            end
            S_UN_N:
            begin
                if (!ph_reg)
                begin
                    if (uhn_reg)
                    begin
                        ph_next = 1'b1;
                    end
                    else
                    begin
                        state_next = S_UN_P;
                    end
                end
                else
                begin
                    wr_hdr.prev     = upr_reg[OFF_W-1:3];
                    wr_hdr.has_prev = uhp_reg;
                    we              = 1'b1;
                    ph_next         = 1'b0;
                    state_next      = S_UN_P;
                end
            end
            S_UN_P:
            begin
                if (!ph_reg)
                begin
                    if (uhp_reg)
                    begin
                        ph_next = 1'b1;
                    end
                    else
                    begin
                        head_next  = un_reg;
                        hv_next    = uhn_reg;
                        state_next = uret_reg;
                    end
                end
                else
                begin
                    wr_hdr.next     = un_reg[OFF_W-1:3];
                    wr_hdr.has_next = uhn_reg;
                    we              = 1'b1;
                    ph_next         = 1'b0;
                    state_next      = uret_reg;
                end
            end
            S_A_SPLIT:
            begin
                if (!ph_reg)
                begin
                    ph_next = 1'b1;
                end
                else
                begin
                    ph_next = 1'b0;
                    if ({2'b00, rd_hdr.size} > SPLIT_MIN + {1'b0, need_reg})
                    begin
                        wr_hdr.size = rs;
                        we          = 1'b1;
                        alu_op      = '{1'b0, f_reg, {1'b0, rs}};
                        up_next     = alu_res;
                        cur_next    = rs;
                        tfree_next  = rd_hdr.free;
                        state_next  = S_A_UP;
                    end
                    else
                    begin
                        state_next = S_A_FREE0;
                    end
                end
            end
            S_A_UP:
            begin
                if (!ph_reg)
                begin
                    ph_next = 1'b1;
                end
                else
                begin
                    wr_hdr.bsize = cur_reg;
                    wr_hdr.bfree = tfree_reg;
                    wr_hdr.size  = need_reg[SIZE_W-1:0];
                    wr_hdr.free  = 1'b0;
                    we           = 1'b1;
                    alu_op       = '{1'b0, up_reg, need_reg};
                    nb_next      = alu_res;
                    ph_next      = 1'b0;
                    state_next   = S_A_UPN;
                end
            end
            S_A_UPN:
            begin
                if (!ph_reg)
                begin
                    ph_next = 1'b1;
                end
                else
                begin
                    wr_hdr.bsize = need_reg[SIZE_W-1:0];
                    wr_hdr.bfree = 1'b0;
                    we           = 1'b1;
                    res_off_next = up_reg + HDR16;
                    ph_next      = 1'b0;
                    state_next   = S_PUSH;
                end
            end
            S_PUSH:
            begin
                if (!ph_reg)
                begin
                    ph_next = 1'b1;
                end
                else
                begin
                    wr_hdr.next     = head_reg[OFF_W-1:3];
                    wr_hdr.has_next = hv_reg;
                    wr_hdr.has_prev = 1'b0;
                    we              = 1'b1;
                    ph_next         = 1'b0;
                    state_next      = S_PUSH_H;
                end
            end
            S_PUSH_H:
            begin
                if (!ph_reg)
                begin
                    if (hv_reg)
                    begin
                        ph_next = 1'b1;
                    end
                    else
                    begin
                        head_next  = f_reg;
                        hv_next    = 1'b1;
                        state_next = S_OUT;
                    end
                end
                else
                begin
                    wr_hdr.prev     = f_reg[OFF_W-1:3];
                    wr_hdr.has_prev = 1'b1;
                    we              = 1'b1;
                    head_next       = f_reg;
                    hv_next         = 1'b1;
                    ph_next         = 1'b0;
                    state_next      = S_OUT;
                end
            end
            S_A_FREE0:
            begin
                if (!ph_reg)
                begin
                    ph_next = 1'b1;
                end
                else
                begin
                    wr_hdr.free = 1'b0;
                    we          = 1'b1;
                    alu_op      = '{1'b0, f_reg, {1'b0, rd_hdr.size}};
                    nb_next     = alu_res;
                    ph_next     = 1'b0;
                    state_next  = S_A_NB;
                end
            end
            S_A_NB:
            begin
                if (!ph_reg)
                begin
                    ph_next = 1'b1;
                end
                else
                begin
                    wr_hdr.bfree = 1'b0;
                    we           = 1'b1;
                    res_off_next = f_reg + HDR16;
                    ph_next      = 1'b0;
                    state_next   = S_OUT;
                end
            end
            S_F_B:
            begin
                if (!ph_reg)
                begin
                    ph_next = 1'b1;
                end
                else
                begin
                    alu_op   = '{1'b0, f_reg, {1'b0, rd_hdr.size}};
                    aft_next = alu_res;
                    bbs_next = rd_hdr.bsize;
                    ph_next  = 1'b0;
                    if (rd_hdr.bfree)
                    begin
                        cur_next   = rd_hdr.bsize + HDR16 + rd_hdr.size;
                        state_next = S_F_PREV;
                    end
                    else
                    begin
                        cur_next   = rd_hdr.size;
                        state_next = S_F_A;
                    end
                end
            end
            S_F_PREV:
            begin
                alu_op     = '{1'b1, f_reg, {1'b0, bbs_reg}};
                bef_next   = alu_res;
                state_next = S_F_BEF;
            end
            S_F_BEF:
            begin
                if (!ph_reg)
                begin
                    ph_next = 1'b1;
                end
                else
                begin
                    uhn_next   = rd_hdr.has_next;
                    uhp_next   = rd_hdr.has_prev;
                    un_next    = off_of(rd_hdr.next);
                    upr_next   = off_of(rd_hdr.prev);
                    uret_next  = S_F_MA;
                    ph_next    = 1'b0;
                    state_next = S_UN_N;
                end
            end
            S_F_MA:
            begin
                if (!ph_reg)
                begin
                    ph_next = 1'b1;
                end
                else
                begin
                    wr_hdr.bsize = cur_reg;
                    wr_hdr.bfree = 1'b1;
                    we           = 1'b1;
                    ph_next      = 1'b0;
                    state_next   = S_F_MB;
                end
            end
            S_F_MB:
            begin
                if (!ph_reg)
                begin
                    ph_next = 1'b1;
                end
                else
                begin
                    wr_hdr.size = cur_reg;
                    wr_hdr.free = 1'b1;
                    we          = 1'b1;
                    f_next      = bef_reg;
                    ph_next     = 1'b0;
                    state_next  = S_F_A;
                end
            end
            S_F_A:
            begin
                if (!ph_reg)
                begin
                    ph_next = 1'b1;
                end
                else
                begin
                    ph_next = 1'b0;
                    if (rd_hdr.free)
                    begin
                        uhn_next   = rd_hdr.has_next;
                        uhp_next   = rd_hdr.has_prev;
                        un_next    = off_of(rd_hdr.next);
                        upr_next   = off_of(rd_hdr.prev);
                        uret_next  = S_F_MC;
                        cur_next   = cur_reg + HDR16 + rd_hdr.size;
                        alu_op     = '{1'b0, aft_reg, {1'b0, rd_hdr.size}};
                        nb_next    = alu_res;
                        state_next = S_UN_N;
                    end
                    else
                    begin
                        state_next = S_F_FIN;
                    end
                end
            end
            S_F_MC:
            begin
                if (!ph_reg)
                begin
                    ph_next = 1'b1;
                end
                else
                begin
                    wr_hdr.size = cur_reg;
                    we          = 1'b1;
                    ph_next     = 1'b0;
                    state_next  = S_F_MD;
                end
            end
            S_F_MD:
            begin
                if (!ph_reg)
                begin
                    ph_next = 1'b1;
                end
                else
                begin
                    wr_hdr.bsize = cur_reg;
                    wr_hdr.bfree = 1'b1;
                    we           = 1'b1;
                    ph_next      = 1'b0;
                    state_next   = S_F_FIN;
                end
            end
            S_F_FIN:
            begin
                if (!ph_reg)
                begin
                    ph_next = 1'b1;
                end
                else
                begin
                    wr_hdr.free = 1'b1;
                    we          = 1'b1;
                    ph_next     = 1'b0;
                    state_next  = S_F_AFT;
                end
            end
            S_F_AFT:
            begin
                if (!ph_reg)
                begin
                    ph_next = 1'b1;
                end
                else
                begin
                    wr_hdr.bfree = 1'b1;
                    we           = 1'b1;
                    ph_next      = 1'b0;
                    state_next   = S_PUSH;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_off_next   = res_off_reg;
                    out_st_next    = res_st_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
                ph_next    = 1'b0;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ph_reg        <= 1'b0;
            head_reg      <= '0;
            hv_reg        <= 1'b1;
            out_valid_reg <= 1'b0;
            w0_reg        <= 1'b0;
            ws_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ph_reg        <= ph_next;
            head_reg      <= head_next;
            hv_reg        <= hv_next;
            out_valid_reg <= out_valid_next;
            if (we && (acc_slot == '0))
            begin
                w0_reg <= 1'b1;
            end
            if (we && (acc_slot == SENT_SLOT))
            begin
                ws_reg <= 1'b1;
            end
        end
    end

    // Advance working registers
    always_ff @(posedge clk)
    begin
        uret_reg    <= uret_next;
        f_reg       <= f_next;
        up_reg      <= up_next;
        nb_reg      <= nb_next;
        bef_reg     <= bef_next;
        aft_reg     <= aft_next;
        un_reg      <= un_next;
        upr_reg     <= upr_next;
        uhn_reg     <= uhn_next;
        uhp_reg     <= uhp_next;
        need_reg    <= need_next;
        cur_reg     <= cur_next;
        bbs_reg     <= bbs_next;
        tfree_reg   <= tfree_next;
        vis_reg     <= vis_next;
        res_off_reg <= res_off_next;
        res_st_reg  <= res_st_next;
        out_off_reg <= out_off_next;
        out_st_reg  <= out_st_next;
        rd_slot_reg <= acc_slot;
    end

`ifndef SYNTHESIS
    a_write_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> ph_reg)
        else $error("header write without a preceding read");

    a_fail_no_offset: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != ST_DONE)) |-> (granted_offset == '0))
        else $error("failed transaction carries an offset");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("ready right after an accepted transaction");
`endif
endmodule
